[rtl/core/smacc_pkg.sv]
// Shared types and constants for the sign-magnitude accumulator ALU.
// Used by smacc_addsub, smacc_muldiv and the top level; no dependencies.
`default_nettype none

package smacc_pkg;

  localparam int MagBits = 14;
  localparam int WordW   = MagBits + 1;
  localparam int CntW    = $clog2(MagBits + 1);

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StDivZero  = 2'd2
  } status_e;

  // operands handed to an arithmetic unit at start
  typedef struct packed {
    logic               sa;
    logic [MagBits-1:0] ma;
    logic               sb;
    logic [MagBits-1:0] mb;
  } req_t;

  // result of an arithmetic unit, done is a single-cycle pulse
  typedef struct packed {
    logic               done;
    logic               sign;
    logic [MagBits-1:0] mag;
    logic               ovf;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/sign_magnitude_accumulator_alu.sv]
// Sign-magnitude accumulator ALU top level; uses smacc_pkg, smacc_addsub, smacc_muldiv.
// A divide by zero bypasses the arithmetic units and returns the accumulator unchanged.
// A new transaction is taken only after the previous result is in the output register;
// the add/sub and mul/div units work one bit per cycle.
// Reset clears the accumulator to +0 and empties the output register.
`default_nettype none

module sign_magnitude_accumulator_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [14:0] memory_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [14:0]      accumulator_value_o,
  output logic [1:0]       status_o
);

  localparam int M = smacc_pkg::MagBits;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StHold
  } state_e;

  state_e                     state_q;
  smacc_pkg::op_e             op_q;
  logic [smacc_pkg::WordW-1:0] acc_q;
  logic [smacc_pkg::WordW-1:0] res_word_q;
  smacc_pkg::status_e         res_st_q;
  logic                       out_valid_q;
  smacc_pkg::status_e         status_q;

  smacc_pkg::op_e  in_op;
  smacc_pkg::req_t req;
  smacc_pkg::res_t as_res, md_res, unit_res;
  logic            accept, zero_divisor, start_as, start_md, out_free;
  logic            fin;
  logic [smacc_pkg::WordW-1:0] fin_word;
  smacc_pkg::status_e          fin_st;

  assign in_op        = smacc_pkg::op_e'(opcode_i);
  assign accept       = in_valid_i && !in_stall_o;
  assign zero_divisor = (in_op == smacc_pkg::OpDiv) && (memory_word_i[M-1:0] == '0);
  assign out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    req.sa = acc_q[M];
    req.ma = acc_q[M-1:0];
    req.sb = memory_word_i[M] ^ (in_op == smacc_pkg::OpSub);
    req.mb = memory_word_i[M-1:0];
  end

  assign start_as = accept && (in_op == smacc_pkg::OpAdd || in_op == smacc_pkg::OpSub);
  assign start_md = accept && !zero_divisor &&
                    (in_op == smacc_pkg::OpMul || in_op == smacc_pkg::OpDiv);

  smacc_addsub u_addsub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_as),
    .req_i   (req),
    .res_o   (as_res)
  );

  smacc_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_md),
    .is_div_i (in_op == smacc_pkg::OpDiv),
    .req_i    (req),
    .res_o    (md_res)
  );

  assign unit_res = (op_q == smacc_pkg::OpAdd || op_q == smacc_pkg::OpSub) ? as_res : md_res;

  always_comb begin
    fin      = 1'b0;
    fin_word = {unit_res.sign, unit_res.mag};
    fin_st   = unit_res.ovf ? smacc_pkg::StOverflow : smacc_pkg::StOk;
    unique case (state_q)
      StIdle: begin
        if (accept && zero_divisor) begin
          fin      = 1'b1;
          fin_word = acc_q;
          fin_st   = smacc_pkg::StDivZero;
        end
      end
      StRun:   fin = unit_res.done;
      StHold: begin
        fin      = 1'b1;
        fin_word = res_word_q;
        fin_st   = res_st_q;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= smacc_pkg::OpAdd;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= smacc_pkg::StOk;
      res_word_q  <= '0;
      res_st_q    <= smacc_pkg::StOk;
    end else begin
      if (accept) begin
        op_q <= in_op;
      end
      if (fin && out_free) begin
        acc_q       <= fin_word;
        status_q    <= fin_st;
        out_valid_q <= 1'b1;
        state_q     <= StIdle;
      end else begin
        if (!out_stall_i) begin
          out_valid_q <= 1'b0;
        end
        if (fin) begin
          res_word_q <= fin_word;
          res_st_q   <= fin_st;
          state_q    <= StHold;
        end else if (accept) begin
          state_q <= StRun;
        end
      end
    end
  end

  assign in_stall_o          = (state_q != StIdle);
  assign out_valid_o         = out_valid_q;
  assign accumulator_value_o = acc_q;
  assign status_o            = status_q;

endmodule

`default_nettype wire

[rtl/core/smacc_addsub.sv]
// Bit-serial sign-magnitude adder: one magnitude bit per cycle, LSB first.
// Depends on smacc_pkg.
`default_nettype none

module smacc_addsub (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire smacc_pkg::req_t req_i,
  output smacc_pkg::res_t    res_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [smacc_pkg::CntW-1:0]    cnt_q;
  logic                          sa_q, sb_q;
  logic [smacc_pkg::MagBits-1:0] a_q, b_q;
  logic [smacc_pkg::MagBits-1:0] sum_q, d1_q, d2_q;
  logic                          c_q, c1_q, c2_q, nz_q;

  logic a_bit, b_bit, s_bit, d1_bit, d2_bit;

  assign a_bit  = a_q[0];
  assign b_bit  = b_q[0];
  assign s_bit  = a_bit ^ b_bit ^ c_q;
  // a - b and b - a run side by side, the final carry picks one
  assign d1_bit = a_bit ^ ~b_bit ^ c1_q;
  assign d2_bit = b_bit ^ ~a_bit ^ c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == smacc_pkg::CntW'(smacc_pkg::MagBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sa_q <= req_i.sa;
      sb_q <= req_i.sb;
      a_q  <= req_i.ma;
      b_q  <= req_i.mb;
      c_q  <= 1'b0;
      c1_q <= 1'b1;
      c2_q <= 1'b1;
      nz_q <= 1'b0;
    end else if (busy_q) begin
      a_q   <= {1'b0, a_q[smacc_pkg::MagBits-1:1]};
      b_q   <= {1'b0, b_q[smacc_pkg::MagBits-1:1]};
      sum_q <= {s_bit, sum_q[smacc_pkg::MagBits-1:1]};
      d1_q  <= {d1_bit, d1_q[smacc_pkg::MagBits-1:1]};
      d2_q  <= {d2_bit, d2_q[smacc_pkg::MagBits-1:1]};
      c_q   <= (a_bit & b_bit) | (c_q & (a_bit ^ b_bit));
      c1_q  <= (a_bit & ~b_bit) | (c1_q & (a_bit ^ ~b_bit));
      c2_q  <= (b_bit & ~a_bit) | (c2_q & (b_bit ^ ~a_bit));
      nz_q  <= nz_q | d1_bit;
    end
  end

  always_comb begin
    res_o.done = done_q;
    res_o.ovf  = 1'b0;
    if (sa_q == sb_q) begin
      res_o.sign = sa_q;
      res_o.mag  = sum_q;
      res_o.ovf  = c_q;
    end else if (!c1_q) begin
      res_o.sign = sb_q;
      res_o.mag  = d2_q;
    end else if (nz_q) begin
      res_o.sign = sa_q;
      res_o.mag  = d1_q;
    end else begin
      // equal magnitudes: positive zero
      res_o.sign = 1'b0;
      res_o.mag  = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/smacc_muldiv.sv]
// Iterative shift-add multiplier and restoring divider, one quotient or
// multiplier bit per cycle. Depends on smacc_pkg.
`default_nettype none

module smacc_muldiv (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          is_div_i,
  input  wire smacc_pkg::req_t req_i,
  output smacc_pkg::res_t    res_o
);

  localparam int M = smacc_pkg::MagBits;

  logic                       busy_q;
  logic                       done_q;
  logic [smacc_pkg::CntW-1:0] cnt_q;
  logic                       div_q;
  logic                       sign_q;
  logic [M-1:0]               hi_q, lo_q, m_q;

  logic [M:0]   mul_sum;
  logic [M+1:0] div_diff;
  logic         borrow;

  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, m_q} : '0);
  assign div_diff = {1'b0, hi_q, lo_q[M-1]} - {2'b00, m_q};
  assign borrow   = div_diff[M+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == smacc_pkg::CntW'(M - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= is_div_i;
      sign_q <= req_i.sa ^ req_i.sb;
      hi_q   <= '0;
      lo_q   <= req_i.ma;
      m_q    <= req_i.mb;
    end else if (busy_q) begin
      if (div_q) begin
        // remainder in hi, dividend shifts out of lo as quotient shifts in
        hi_q <= borrow ? {hi_q[M-2:0], lo_q[M-1]} : div_diff[M-1:0];
        lo_q <= {lo_q[M-2:0], ~borrow};
      end else begin
        hi_q <= mul_sum[M:1];
        lo_q <= {mul_sum[0], lo_q[M-1:1]};
      end
    end
  end

  always_comb begin
    res_o.done = done_q;
    res_o.sign = sign_q;
    res_o.mag  = lo_q;
    res_o.ovf  = !div_q && (hi_q != '0);
  end

endmodule

`default_nettype wire

[test/tb_sign_magnitude_accumulator_alu.sv]
// Self-checking testbench for sign_magnitude_accumulator_alu: a directed table, then random
// opcode/operand transactions, with a local accumulator predictor and random idling on both sides.
// Depends on smacc_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_sign_magnitude_accumulator_alu;
  import smacc_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 400;
  localparam int DrainCycles   = 2 * (MagBits + 2);
  localparam int NumDirected   = 25;

  typedef struct packed {
    logic [WordW-1:0] acc;
    status_e          st;
  } acc_result_t;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] word;
    logic             typed;  // expected result given in the row
    logic [WordW-1:0] acc;
    status_e          st;
  } stim_row_t;

  // Walks from reset through overflow, zero differences, -0 operands and divide by zero.
  localparam stim_row_t DirectedRows [0:NumDirected-1] = '{
    '{OpAdd, 15'h3fff, 1'b1, 15'h3fff, StOk},
    '{OpSub, 15'h3fff, 1'b1, 15'h0000, StOk},
    '{OpSub, 15'h3fff, 1'b1, 15'h7fff, StOk},
    '{OpAdd, 15'h3fff, 1'b1, 15'h0000, StOk},
    '{OpAdd, 15'h3fff, 1'b1, 15'h3fff, StOk},
    '{OpAdd, 15'h0001, 1'b1, 15'h0000, StOverflow},
    '{OpSub, 15'h0000, 1'b1, 15'h0000, StOk},
    '{OpAdd, 15'h4000, 1'b1, 15'h0000, StOk},
    '{OpDiv, 15'h0000, 1'b1, 15'h0000, StDivZero},
    '{OpDiv, 15'h4000, 1'b1, 15'h0000, StDivZero},
    '{OpSub, 15'h3fff, 1'b1, 15'h7fff, StOk},
    '{OpSub, 15'h4001, 1'b0, 15'h0000, StOk},
    '{OpAdd, 15'h7fff, 1'b0, 15'h0000, StOk},
    '{OpMul, 15'h4001, 1'b0, 15'h0000, StOk},
    '{OpMul, 15'h0002, 1'b0, 15'h0000, StOk},
    '{OpDiv, 15'h7fff, 1'b0, 15'h0000, StOk},
    '{OpMul, 15'h0000, 1'b0, 15'h0000, StOk},
    '{OpAdd, 15'h0005, 1'b0, 15'h0000, StOk},
    '{OpDiv, 15'h4000, 1'b0, 15'h0000, StOk},
    '{OpMul, 15'h3fff, 1'b0, 15'h0000, StOk},
    '{OpDiv, 15'h0001, 1'b0, 15'h0000, StOk},
    '{OpSub, 15'h4000, 1'b0, 15'h0000, StOk},
    '{OpMul, 15'h7fff, 1'b0, 15'h0000, StOk},
    '{OpDiv, 15'h2a55, 1'b0, 15'h0000, StOk},
    '{OpAdd, 15'h1555, 1'b0, 15'h0000, StOk}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [1:0]       opcode_i      = OpAdd;
  logic [WordW-1:0] memory_word_i = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [WordW-1:0] accumulator_value_o;
  logic [1:0]       status_o;

  logic [WordW-1:0] model_acc = '0;
  acc_result_t      pending_results [$];
  acc_result_t      head;
  bit               quiet_stretch = 1'b0;
  int               mismatches    = 0;
  int               results_seen  = 0;
  int               items_sent    = 0;
  int               idle_cycles   = 0;
  int               op_count [4]  = '{0, 0, 0, 0};
  int               status_count [3] = '{0, 0, 0};

  sign_magnitude_accumulator_alu DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .memory_word_i      (memory_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accumulator_value_o(accumulator_value_o),
    .status_o           (status_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Applies one operation to the local accumulator and gives the status it raises.
  function automatic void alu_apply(input op_e op, input logic [WordW-1:0] word,
                                    inout logic [WordW-1:0] acc, output status_e st);
    logic                 sa, sb;
    logic [MagBits-1:0]   ma, mb;
    logic [MagBits:0]     sum;
    logic [2*MagBits-1:0] prod;
    sa = acc[MagBits];
    ma = acc[MagBits-1:0];
    sb = word[MagBits];
    mb = word[MagBits-1:0];
    st = StOk;
    case (op)
      OpAdd, OpSub: begin
        if (op == OpSub) sb = ~sb;
        if (sa == sb) begin
          sum = {1'b0, ma} + {1'b0, mb};
          if (sum[MagBits]) st = StOverflow;
          acc = {sa, sum[MagBits-1:0]};
        end else if (ma > mb) begin
          acc = {sa, ma - mb};
        end else if (mb > ma) begin
          acc = {sb, mb - ma};
        end else begin
          acc = '0;  // zero difference is always +0
        end
      end
      OpMul: begin
        prod = (2*MagBits)'(ma) * (2*MagBits)'(mb);
        if (prod[2*MagBits-1:MagBits] != '0) st = StOverflow;
        acc = {sa ^ sb, prod[MagBits-1:0]};
      end
      default: begin
        if (mb == '0) st = StDivZero;  // accumulator left as it was
        else acc = {sa ^ sb, ma / mb};
      end
    endcase
  endfunction

  // Presents one transaction, waits for it to be taken and queues what it must return.
  task automatic issue(input op_e op, input logic [WordW-1:0] word,
                       input logic typed, input acc_result_t typed_res);
    acc_result_t pred;
    status_e     st;
    while (!quiet_stretch && $urandom_range(99) < 7) begin
      in_valid_i    <= 1'b0;
      opcode_i      <= 2'($urandom_range(3));
      memory_word_i <= WordW'($urandom);
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    memory_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    alu_apply(op, word, model_acc, st);
    pred.acc = model_acc;
    pred.st  = st;
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
    op_count[op]++;
  endtask

  task automatic hold_until_drained;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic flag_mismatch(input string what, input acc_result_t want);
    if (mismatches < 10)
      $display("%0t: %s: expected acc=%h status=%0d, got acc=%h status=%0d", $realtime, what,
               want.acc, want.st, accumulator_value_o, status_o);
    mismatches++;
  endtask

  // Result side: checks each transaction against the oldest expectation, stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (status_o < 3) status_count[status_o]++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0);
      end else begin
        head = pending_results.pop_front();
        if (accumulator_value_o !== head.acc || status_o !== head.st)
          flag_mismatch("result mismatch", head);
      end
    end
    out_stall_i <= !quiet_stretch && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results pending", idle_cycles,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t        row;
    acc_result_t      typed_res;
    logic [WordW-1:0] word;
    op_e              op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      typed_res.acc = row.acc;
      typed_res.st  = row.st;
      issue(row.op, row.word, row.typed, typed_res);
    end
    hold_until_drained();

    for (int i = 0; i < RandomItems; i++) begin
      quiet_stretch = (i >= 150 && i < 250);
      if (i == 300) hold_until_drained();
      op = op_e'($urandom_range(3));
      case ($urandom_range(9))
        0:       word = {1'($urandom), {MagBits{1'b0}}};                 // +0 or -0
        1:       word = {1'($urandom), {MagBits{1'b1}}};                 // largest magnitude
        2, 3:    word = {1'($urandom), MagBits'($urandom_range(15))};   // small magnitudes
        4:       word = {1'($urandom), model_acc[MagBits-1:0]};         // same magnitude
        default: word = WordW'($urandom);
      endcase
      issue(op, word, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d transactions (add %0d, sub %0d, mul %0d, div %0d), checked %0d results",
             items_sent, op_count[OpAdd], op_count[OpSub], op_count[OpMul], op_count[OpDiv],
             results_seen);
    $display("Status seen: ok %0d, overflow %0d, divide by zero %0d; %0d mismatches",
             status_count[StOk], status_count[StOverflow], status_count[StDivZero], mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sign_magnitude_accumulator_alu.f]
rtl/core/smacc_pkg.sv
rtl/core/smacc_addsub.sv
rtl/core/smacc_muldiv.sv
rtl/core/sign_magnitude_accumulator_alu.sv
test/tb_sign_magnitude_accumulator_alu.sv
